>>> rtl/core/pkn_pkg.sv
// pkn_pkg: shared types and constants for the path key normaliser and hasher
// used by pkn_fnv_unit, pkn_ctrl, path_key_normalize_hash and pkn_checker
package pkn_pkg;

    // fnv-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // character codes
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // result field widths
    localparam int unsigned SLOT_W = 15;
    localparam int unsigned LEN_W  = 9;

    // leading-part phase of the path
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_DOT   = 2'd1,
        PH_SKIP  = 2'd2,
        PH_BODY  = 2'd3
    } lead_phase_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PROC = 2'd1,
        ST_SEND = 2'd2
    } seq_state_t;

    // command to the shared hash unit
    typedef struct packed {
        logic       step;
        logic       init;
        logic [7:0] ch;
    } hash_cmd_t;

    // result item from the sequencer, without the hash fields
    typedef struct packed {
        logic             valid;
        logic [7:0]       key_char;
        logic             char_valid;
        logic             key_done;
        logic [LEN_W-1:0] key_length;
        logic             key_empty;
    } result_t;

endpackage

>>> rtl/core/pkn_fnv_unit.sv
// pkn_fnv_unit: running fnv-1a hash register with one shared xor-multiply step
// depends on pkn_pkg
module pkn_fnv_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pkn_pkg::hash_cmd_t    cmd,
    output logic [31:0]           hash
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] mixed;

    // one fold per step, truncated product
    always_comb
    begin
        mixed     = hash_reg ^ {24'd0, cmd.ch};
        hash_next = hash_reg;
        if (cmd.init)
        begin
            hash_next = pkn_pkg::FNV_BASIS;
        end
        else if (cmd.step)
        begin
            hash_next = 32'(mixed * pkn_pkg::FNV_PRIME);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= pkn_pkg::FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

>>> rtl/core/pkn_ctrl.sv
// pkn_ctrl: sequencer for path normalisation, one body character per cycle unless a held slash is released first
// depends on pkn_pkg; drives the shared hash unit through a hash_cmd_t
module pkn_ctrl
#(
    parameter int unsigned KEY_CAPACITY = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic                  out_ready,
    output pkn_pkg::result_t      result,
    output pkn_pkg::hash_cmd_t    hash_cmd
);

    localparam int unsigned CW = (KEY_CAPACITY > 2) ? $clog2(KEY_CAPACITY) : 1;
    localparam logic [CW-1:0] KEPT_MAX = CW'(KEY_CAPACITY - 1);

    pkn_pkg::seq_state_t  state_reg, state_next;
    pkn_pkg::lead_phase_t phase_reg, phase_next;
    logic                 slash_reg, slash_next;
    logic [CW-1:0]        kept_reg, kept_next;
    logic [7:0]           bc_reg [2];
    logic [7:0]           bc_next [2];
    logic [1:0]           bc_cnt_reg, bc_cnt_next;
    logic                 bc_idx_reg, bc_idx_next;
    logic                 last_reg, last_next;
    logic [7:0]           ebuf_reg [2];
    logic [7:0]           ebuf_next [2];
    logic [1:0]           ecnt_reg, ecnt_next;
    logic                 send_idx_reg, send_idx_next;

    // accept-time decode
    logic                 sep;
    logic [7:0]           mapped;
    pkn_pkg::lead_phase_t phase_acc;
    logic [1:0]           list_cnt;
    logic [7:0]           list0, list1;

    // per-cycle body character work
    logic [7:0]           cur;
    logic [7:0]           cur_lower;
    logic                 full;
    logic                 advance;
    logic                 emit;
    logic [7:0]           emit_ch;
    logic                 send_end;
    logic [CW-1:0]        len;

    // leading dot, separators and the list of body characters for this request
    always_comb
    begin
        sep       = (in_byte == pkn_pkg::CHAR_SLASH) || (in_byte == pkn_pkg::CHAR_BSLASH);
        mapped    = sep ? pkn_pkg::CHAR_SLASH : in_byte;
        phase_acc = phase_reg;
        list_cnt  = 2'd0;
        list0     = mapped;
        list1     = mapped;
        unique case (phase_reg)
            pkn_pkg::PH_START:
            begin
                priority if (in_byte == pkn_pkg::CHAR_DOT)
                begin
                    phase_acc = pkn_pkg::PH_DOT;
                end
                else if (sep)
                begin
                    phase_acc = pkn_pkg::PH_SKIP;
                end
                else
                begin
                    phase_acc = pkn_pkg::PH_BODY;
                    list_cnt  = 2'd1;
                end
            end
            pkn_pkg::PH_DOT:
            begin
                if (sep)
                begin
                    phase_acc = pkn_pkg::PH_SKIP;
                end
                else
                begin
                    phase_acc = pkn_pkg::PH_BODY;
                    list0     = pkn_pkg::CHAR_DOT;
                    list_cnt  = 2'd2;
                end
            end
            pkn_pkg::PH_SKIP:
            begin
                if (!sep)
                begin
                    phase_acc = pkn_pkg::PH_BODY;
                    list_cnt  = 2'd1;
                end
            end
            pkn_pkg::PH_BODY:
            begin
                list_cnt = 2'd1;
            end
            default:
            begin
                list_cnt = 2'd0;
            end
        endcase
        // a lone leading dot at the end of the path becomes the key
        if (in_last && (phase_acc == pkn_pkg::PH_DOT))
        begin
            phase_acc = pkn_pkg::PH_BODY;
            list0     = pkn_pkg::CHAR_DOT;
            list_cnt  = 2'd1;
        end
    end

    // current body character, lower case, capacity test, send end and length
    always_comb
    begin
        cur       = bc_reg[bc_idx_reg];
        full      = (kept_reg == KEPT_MAX);
        cur_lower = ((cur >= pkn_pkg::CHAR_UPPER_A) && (cur <= pkn_pkg::CHAR_UPPER_Z)) ?
                    (cur + pkn_pkg::CASE_OFFSET) : cur;
        send_end  = (send_idx_reg == ((ecnt_reg == 2'd2) ? 1'b1 : 1'b0));
        len       = kept_reg - CW'(slash_reg);
    end

    // next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        slash_next    = slash_reg;
        kept_next     = kept_reg;
        bc_next       = bc_reg;
        bc_cnt_next   = bc_cnt_reg;
        bc_idx_next   = bc_idx_reg;
        last_next     = last_reg;
        ebuf_next     = ebuf_reg;
        ecnt_next     = ecnt_reg;
        send_idx_next = send_idx_reg;
        advance       = 1'b0;
        emit          = 1'b0;
        emit_ch       = cur_lower;
        hash_cmd      = '0;
        unique case (state_reg)
            pkn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    bc_next[0]    = list0;
                    bc_next[1]    = list1;
                    bc_cnt_next   = list_cnt;
                    bc_idx_next   = 1'b0;
                    last_next     = in_last;
                    phase_next    = phase_acc;
                    ecnt_next     = 2'd0;
                    send_idx_next = 1'b0;
                    priority if (list_cnt != 2'd0)
                    begin
                        state_next = pkn_pkg::ST_PROC;
                    end
                    else if (in_last)
                    begin
                        state_next = pkn_pkg::ST_SEND;
                    end
                    else
                    begin
                        state_next = pkn_pkg::ST_IDLE;
                    end
                end
            end
            pkn_pkg::ST_PROC:
            begin
                advance = 1'b1;
                priority if (full)
                begin
                    advance = 1'b1;
                end
                else if (cur == pkn_pkg::CHAR_SLASH)
                begin
                    if (!slash_reg)
                    begin
                        slash_next = 1'b1;
                        kept_next  = kept_reg + CW'(1);
                    end
                end
                else if (slash_reg)
                begin
                    // release the held slash, then revisit this character
                    emit       = 1'b1;
                    emit_ch    = pkn_pkg::CHAR_SLASH;
                    slash_next = 1'b0;
                    advance    = 1'b0;
                end
                else
                begin
                    emit      = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                if (emit)
                begin
                    ebuf_next[ecnt_reg[0]] = emit_ch;
                    ecnt_next              = ecnt_reg + 2'd1;
                    hash_cmd.step          = 1'b1;
                    hash_cmd.ch            = emit_ch;
                end
                if (advance)
                begin
                    if ({1'b0, bc_idx_reg} == (bc_cnt_reg - 2'd1))
                    begin
                        state_next = ((ecnt_next == 2'd0) && !last_reg) ?
                                     pkn_pkg::ST_IDLE : pkn_pkg::ST_SEND;
                    end
                    else
                    begin
                        bc_idx_next = 1'b1;
                    end
                end
            end
            pkn_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    if (send_end)
                    begin
                        state_next = pkn_pkg::ST_IDLE;
                        if (last_reg)
                        begin
                            phase_next    = pkn_pkg::PH_START;
                            slash_next    = 1'b0;
                            kept_next     = '0;
                            hash_cmd.init = 1'b1;
                        end
                    end
                    else
                    begin
                        send_idx_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pkn_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and result outputs
    always_comb
    begin
        in_ready          = (state_reg == pkn_pkg::ST_IDLE);
        result.valid      = (state_reg == pkn_pkg::ST_SEND);
        result.char_valid = (ecnt_reg != 2'd0);
        result.key_char   = (ecnt_reg != 2'd0) ? ebuf_reg[send_idx_reg] : 8'd0;
        result.key_done   = last_reg && send_end;
        result.key_length = result.key_done ? pkn_pkg::LEN_W'(len) : '0;
        result.key_empty  = result.key_done && (len == '0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pkn_pkg::ST_IDLE;
            phase_reg    <= pkn_pkg::PH_START;
            slash_reg    <= 1'b0;
            kept_reg     <= '0;
            bc_cnt_reg   <= 2'd0;
            bc_idx_reg   <= 1'b0;
            last_reg     <= 1'b0;
            ecnt_reg     <= 2'd0;
            send_idx_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            slash_reg    <= slash_next;
            kept_reg     <= kept_next;
            bc_cnt_reg   <= bc_cnt_next;
            bc_idx_reg   <= bc_idx_next;
            last_reg     <= last_next;
            ecnt_reg     <= ecnt_next;
            send_idx_reg <= send_idx_next;
        end
    end

    // character buffers
    always_ff @(posedge clk)
    begin
        bc_reg   <= bc_next;
        ebuf_reg <= ebuf_next;
    end

endmodule

>>> rtl/core/path_key_normalize_hash.sv
// path_key_normalize_hash: turns a byte stream of paths into lookup key characters
// and a 32-bit fnv-1a hash; depends on pkn_pkg, pkn_fnv_unit and pkn_ctrl
//
// Usage:
//   s_axis carries one path byte per request, tlast on the final byte of a path.
//   m_axis carries result requests: one per key character released, and on the
//   last request of a path tlast with the hash, table slot, length and empty flag.
//   A path end that releases no character gives one request with tuser[0] low.
//   After an input request is taken, the sequencer steps through its body
//   characters, releasing a held slash before the next one, and folds each
//   released character (at most two per byte) through the single shared
//   xor-multiply unit; results then go out one per cycle while m_axis_tready
//   is high. A byte that releases nothing and ends no path gives no request.
//   s_axis_tready is low from acceptance until all results are taken.
//   When m_axis_tready is low the current result holds steady and no input is
//   taken. Reset clears the path state and restores the hash to its basis.
module path_key_normalize_hash
#(
    parameter int unsigned KEY_CAPACITY = 512,
    parameter int unsigned SLOT_BITS    = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // path_byte
    input  logic        s_axis_tlast,   // end_of_path
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // key_char, key_hash, table_slot, key_length
    output logic [1:0]  m_axis_tuser,   // char_valid, key_empty
    output logic        m_axis_tlast    // key_done
);

    pkn_pkg::hash_cmd_t hash_cmd;
    pkn_pkg::result_t   result;
    logic [31:0]        hash;
    logic [31:0]        key_hash;
    logic [SLOT_BITS-1:0] slot_raw;
    logic [pkn_pkg::SLOT_W-1:0] table_slot;

    pkn_fnv_unit u_fnv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hash_cmd),
        .hash  (hash)
    );

    pkn_ctrl
    #(
        .KEY_CAPACITY (KEY_CAPACITY)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_ready (m_axis_tready),
        .result    (result),
        .hash_cmd  (hash_cmd)
    );

    // hash fields only on the final request of a path
    always_comb
    begin
        slot_raw   = hash[SLOT_BITS-1:0];
        key_hash   = result.key_done ? hash : 32'd0;
        table_slot = result.key_done ? pkn_pkg::SLOT_W'(slot_raw) : '0;
    end

    // output packing
    assign m_axis_tvalid = result.valid;
    assign m_axis_tlast  = result.key_done;
    assign m_axis_tuser  = {result.key_empty, result.char_valid};
    assign m_axis_tdata  = {result.key_length, table_slot, key_hash, result.key_char};

endmodule

>>> rtl/core/pkn_checker.sv
// pkn_checker: port-level checks on path_key_normalize_hash, bound to the top level
// depends on pkn_pkg
module pkn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // one request in flight: no input taken while a result is shown
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
        $stable(m_axis_tlast))
        else $error("stalled result changed");

    // an empty key reports the basis hash, zero length and no character
    a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser[1] |->
        m_axis_tdata[39:8] == pkn_pkg::FNV_BASIS && m_axis_tdata[63:55] == 9'd0 &&
        !m_axis_tuser[0])
        else $error("empty key with wrong summary");

    // a non-final request is a bare key character
    a_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
        m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata[63:8] == 56'd0)
        else $error("non-final request carries summary fields");

endmodule

bind path_key_normalize_hash pkn_checker u_pkn_checker (.*);
